[design/skinny_pkg.sv]
`timescale 1ns / 1ps

package skinny_pkg;

   localparam int ROUNDS = 48;

   localparam int BLOCK_BITS = 128;
   localparam int HALF_BITS  = 64;
   localparam int ROW_BITS   = 32;
   localparam int CELL_BITS  = 8;
   localparam int CELLS      = BLOCK_BITS / CELL_BITS;
   localparam int RC_BITS    = 6;

   // register indexes of the configuration port
   localparam int CSR_INDEX_BITS = 2;
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_TK1_LOW  = 2'd0,
      CSR_TK1_HIGH = 2'd1,
      CSR_TK2_LOW  = 2'd2,
      CSR_TK2_HIGH = 2'd3
   } csr_index_type;

   typedef logic [BLOCK_BITS-1:0] block_type;
   typedef logic [ROW_BITS-1:0]   row_type;
   typedef logic [RC_BITS-1:0]    rc_type;

   // new cell i takes old cell PERM[i]
   localparam logic [3:0] PERM [CELLS] = '{
      4'd9, 4'd15, 4'd8, 4'd13, 4'd10, 4'd14, 4'd12, 4'd11,
      4'd0, 4'd1,  4'd2, 4'd3,  4'd4,  4'd5,  4'd6,  4'd7
   };

   // 8-bit s-box on the four cells of a row
   function automatic row_type sbox_row(row_type din);
      row_type x;
      row_type y;
      x = ~din;
      x = x ^ (((x >> 2) & (x >> 3)) & 32'h11111111);
      y = ((x << 5) & (x << 1)) & 32'h20202020;
      x = x ^ ((((x << 5) & (x << 4)) & 32'h40404040) ^ y);
      y = ((x << 2) & (x << 1)) & 32'h80808080;
      x = x ^ ((((x >> 2) & (x << 1)) & 32'h02020202) ^ y);
      y = ((x >> 5) & (x << 1)) & 32'h04040404;
      x = x ^ ((((x >> 1) & (x >> 2)) & 32'h08080808) ^ y);
      x = ~x;
      return ((x & 32'h08080808) << 1) |
             ((x & 32'h32323232) << 2) |
             ((x & 32'h01010101) << 5) |
             ((x & 32'h80808080) >> 6) |
             ((x & 32'h40404040) >> 4) |
             ((x & 32'h04040404) >> 2);
   endfunction

   // per-cell lfsr: (x6..x0, x7^x5)
   function automatic row_type lfsr2_row(row_type x);
      return ((x << 1) & 32'hFEFEFEFE) ^ (((x >> 7) ^ (x >> 5)) & 32'h01010101);
   endfunction

   function automatic block_type permute_tk(block_type tk);
      block_type p;
      for (int i = 0; i < CELLS; i++) begin
         p[i*CELL_BITS +: CELL_BITS] = tk[PERM[i]*CELL_BITS +: CELL_BITS];
      end
      return p;
   endfunction

   function automatic block_type tk2_update(block_type tk);
      block_type p;
      p = permute_tk(tk);
      return {p[BLOCK_BITS-1:HALF_BITS],
              lfsr2_row(p[HALF_BITS-1:ROW_BITS]),
              lfsr2_row(p[ROW_BITS-1:0])};
   endfunction

   // round constant of round r (from 0), evaluated at elaboration
   function automatic rc_type rc_at(int r);
      rc_type rc;
      rc = '0;
      for (int i = 0; i <= r; i++) begin
         rc = {rc[4:0], rc[5] ^ rc[4] ^ 1'b1};
      end
      return rc;
   endfunction

   // one full round: s-box, key and constant add, row shift, column mix
   function automatic block_type round_fn(block_type st, logic [HALF_BITS-1:0] rk,
                                          rc_type rc);
      row_type s0, s1, s2, s3, tmp;
      s0 = sbox_row(st[ROW_BITS-1:0]);
      s1 = sbox_row(st[2*ROW_BITS-1:ROW_BITS]);
      s2 = sbox_row(st[3*ROW_BITS-1:2*ROW_BITS]);
      s3 = sbox_row(st[4*ROW_BITS-1:3*ROW_BITS]);
      s0 = s0 ^ rk[ROW_BITS-1:0] ^ {28'd0, rc[3:0]};
      s1 = s1 ^ rk[HALF_BITS-1:ROW_BITS] ^ {30'd0, rc[5:4]};
      s2 = s2 ^ 32'h00000002;
      s1 = {s1[23:0], s1[31:24]};
      s2 = {s2[15:0], s2[31:16]};
      s3 = {s3[7:0],  s3[31:8]};
      s1  = s1 ^ s2;
      s2  = s2 ^ s0;
      tmp = s3 ^ s2;
      return {s2, s1, s0, tmp};
   endfunction

endpackage

[design/skinny_128_256_block_encrypt_core.sv]
`timescale 1ns / 1ps
// a request passes through the 48 round stages (one round per stage); the last stage is the response register
// throughput: one block per cycle; the 48-stage round pipeline takes a new block
// at every edge unless the response register is held by rsp_stall
// reset: synchronous, active high; clears all stage valid bits and sets TK1 and
// TK2 to zero; payload registers are not reset
module skinny_128_256_block_encrypt_core (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration writes
   input  logic                                  csr_wr_en,
   input  logic [skinny_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [skinny_pkg::HALF_BITS-1:0]      csr_wr_data,
   // plaintext channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [skinny_pkg::HALF_BITS-1:0]      req_block_low,
   input  logic [skinny_pkg::HALF_BITS-1:0]      req_block_high,
   // ciphertext channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [skinny_pkg::HALF_BITS-1:0]      rsp_cipher_low,
   output logic [skinny_pkg::HALF_BITS-1:0]      rsp_cipher_high
);
   import skinny_pkg::*;

   // tweakey registers
   logic [HALF_BITS-1:0] tk1_low_ff, tk1_high_ff, tk2_low_ff, tk2_high_ff;

   // round pipeline: stage i holds the state after round i and the tweakeys
   // already stepped for round i+1
   block_type         state_ff [ROUNDS];
   block_type         tk1_ff   [ROUNDS];
   block_type         tk2_ff   [ROUNDS];
   logic [ROUNDS-1:0] valid_ff;

   block_type         state_in [ROUNDS];
   block_type         tk1_in   [ROUNDS];
   block_type         tk2_in   [ROUNDS];
   logic [ROUNDS-1:0] valid_in;

   logic advance;

   // the whole pipeline moves as one; it only halts while the final
   // stage holds a response that the sink is not taking
   assign advance   = !(valid_ff[ROUNDS-1] && rsp_stall);
   assign req_stall = !advance;

   // config writes; the user must issue them only while the pipeline is empty, the block itself does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         tk1_low_ff  <= '0;
         tk1_high_ff <= '0;
         tk2_low_ff  <= '0;
         tk2_high_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_TK1_LOW:  tk1_low_ff  <= csr_wr_data;
            CSR_TK1_HIGH: tk1_high_ff <= csr_wr_data;
            CSR_TK2_LOW:  tk2_low_ff  <= csr_wr_data;
            CSR_TK2_HIGH: tk2_high_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   for (genvar i = 0; i < ROUNDS; i++) begin : g_round
      localparam rc_type RC = rc_at(i);
      block_type st_src, tk1_src, tk2_src;
      logic      vld_src;

      if (i == 0) begin : g_first
         // first round works straight off the request and the config
         assign st_src  = {req_block_high, req_block_low};
         assign tk1_src = {tk1_high_ff, tk1_low_ff};
         assign tk2_src = {tk2_high_ff, tk2_low_ff};
         assign vld_src = req_valid;
      end else begin : g_next
         assign st_src  = state_ff[i-1];
         assign tk1_src = tk1_ff[i-1];
         assign tk2_src = tk2_ff[i-1];
         assign vld_src = valid_ff[i-1];
      end

      // round key is rows 0 and 1 of tk1 ^ tk2
      assign state_in[i] = round_fn(st_src,
                                    tk1_src[HALF_BITS-1:0] ^ tk2_src[HALF_BITS-1:0], RC);
      assign tk1_in[i]   = permute_tk(tk1_src);
      assign tk2_in[i]   = tk2_update(tk2_src);
      assign valid_in[i] = vld_src;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (advance) begin
            valid_ff[i] <= valid_in[i];
         end
      end

      // payload has no reset
      always_ff @(posedge clock) begin
         if (advance) begin
            state_ff[i] <= state_in[i];
            tk1_ff[i]   <= tk1_in[i];
            tk2_ff[i]   <= tk2_in[i];
         end
      end
   end

   // last stage is the response register
   assign rsp_valid       = valid_ff[ROUNDS-1];
   assign rsp_cipher_low  = state_ff[ROUNDS-1][HALF_BITS-1:0];
   assign rsp_cipher_high = state_ff[ROUNDS-1][BLOCK_BITS-1:HALF_BITS];

endmodule

[design/skinny_checker.sv]
`timescale 1ns / 1ps
module skinny_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  csr_wr_en,
   input logic [skinny_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input logic [skinny_pkg::HALF_BITS-1:0]      csr_wr_data,
   input logic                                  req_valid,
   input logic                                  req_stall,
   input logic [skinny_pkg::HALF_BITS-1:0]      req_block_low,
   input logic [skinny_pkg::HALF_BITS-1:0]      req_block_high,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic [skinny_pkg::HALF_BITS-1:0]      rsp_cipher_low,
   input logic [skinny_pkg::HALF_BITS-1:0]      rsp_cipher_high
);
   import skinny_pkg::*;

   // a held response keeps its data
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cipher_low)
                                 && $stable(rsp_cipher_high))
      else $error("response changed while stalled");

   // input only backs up behind a held response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a held response");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind skinny_128_256_block_encrypt_core skinny_checker u_skinny_checker (.*);

[bench/tb_skinny_128_256_block_encrypt_core.sv]
`timescale 1ns / 1ps

module tb_skinny_128_256_block_encrypt_core;

   import skinny_pkg::*;

   // receiver hold-off long enough to back the 48-stage pipeline up into req_stall
   localparam int HOLD_STALL_CYCLES = 300;
   // drain margin after the last expected transfer, a bit over the pipeline depth
   localparam int DRAIN_MARGIN = 64;
   localparam int DRAIN_LIMIT = 20000;
   localparam int CHUNKS_PER_PHASE = 4;
   localparam int BLOCKS_PER_CHUNK = 92;

   typedef struct packed {
      logic [HALF_BITS-1:0] cipher_low;
      logic [HALF_BITS-1:0] cipher_high;
   } cipher_pair_type;

   // one directed row: tweakey halves and plaintext, byte 0 in bits 7:0
   typedef struct packed {
      logic [BLOCK_BITS-1:0] tk1;
      logic [BLOCK_BITS-1:0] tk2;
      logic [BLOCK_BITS-1:0] plain;
   } directed_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_wr_en = 1'b0;
   csr_index_type        csr_index = CSR_TK1_LOW;
   logic [HALF_BITS-1:0] csr_wr_data = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [HALF_BITS-1:0] req_block_low = '0;
   logic [HALF_BITS-1:0] req_block_high = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [HALF_BITS-1:0] rsp_cipher_low;
   logic [HALF_BITS-1:0] rsp_cipher_high;

   // shadow of the tweakey registers as last written
   logic [HALF_BITS-1:0] tweakey_word [4] = '{default: '0};

   cipher_pair_type pending_cipher [$];
   cipher_pair_type head_cipher;
   int mismatch_count = 0;

   // idle rates in percent; the receiver's is handed over by nonblocking write
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // hold-off requests from the stimulus side, counted off by the receiver
   int hold_requests = 0;
   int hold_seen = 0;
   int hold_left = 0;

   // tweakey cell permutation: new cell i takes old cell tk_perm[i]
   int tk_perm [16] = '{9, 15, 8, 13, 10, 14, 12, 11, 0, 1, 2, 3, 4, 5, 6, 7};

   directed_row_type directed_rows [16] = '{
      // reset tweakey, no register written yet
      '{128'h0, 128'h0, 128'h0},
      '{128'h0, 128'h0, {BLOCK_BITS{1'b1}}},
      '{128'h0, 128'h0, 128'h0f0e0d0c0b0a09080706050403020100},
      '{128'h0, 128'h0, 128'h1},
      '{128'h0, 128'h0, {1'b1, 127'h0}},
      // each tweakey half alone at its extremes
      '{{BLOCK_BITS{1'b1}}, 128'h0, 128'h0},
      '{{BLOCK_BITS{1'b1}}, 128'h0, {BLOCK_BITS{1'b1}}},
      '{128'h0, {BLOCK_BITS{1'b1}}, 128'h0},
      '{128'h0, {BLOCK_BITS{1'b1}}, {BLOCK_BITS{1'b1}}},
      // equal halves cancel in the first round key, then complementary halves
      '{{BLOCK_BITS{1'b1}}, {BLOCK_BITS{1'b1}}, 128'h0},
      '{{BLOCK_BITS{1'b1}}, {BLOCK_BITS{1'b1}}, {64{2'b10}}},
      '{{64{2'b10}}, {64{2'b01}}, {64{2'b01}}},
      // byte order checks with mixed byte values
      '{128'hf3a1d785309eaed2c14a5d6081ec9c00, 128'hb3cadfedce4610f0dcfd00fceb23c11a,
        128'h252e02e795a682d38da6267a76470c3a},
      '{128'h1, {1'b1, 127'h0}, {BLOCK_BITS{1'b1}}},
      '{128'h0123456789abcdef_fedcba9876543210, 128'h0123456789abcdef_fedcba9876543210,
        128'hdeadbeef_00000000_ffffffff_12345678},
      // back to an all-zero tweakey after non-zero ones
      '{128'h0, 128'h0, 128'h0}
   };

   skinny_128_256_block_encrypt_core dut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_block_low   (req_block_low),
      .req_block_high  (req_block_high),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_cipher_low  (rsp_cipher_low),
      .rsp_cipher_high (rsp_cipher_high)
   );

   always #5 clock = ~clock;

   // watchdog: far beyond the slowest correct run
   initial begin
      #2000000;
      $display("simulation failed");
      $finish;
   end

   task automatic report_mismatch(input string what);
      $display("ERROR at %0t ns: %s", $time, what);
      mismatch_count++;
   endtask

   // cell-wise SKINNY-128-256 encryption of one block under the given tweakey
   function automatic logic [BLOCK_BITS-1:0] skinny_encrypt(
         input logic [BLOCK_BITS-1:0] plain,
         input logic [BLOCK_BITS-1:0] tk1_in,
         input logic [BLOCK_BITS-1:0] tk2_in);
      logic [7:0] st [16];
      logic [7:0] sh [16];
      logic [7:0] t1 [16];
      logic [7:0] t2 [16];
      logic [7:0] nt1 [16];
      logic [7:0] nt2 [16];
      logic [7:0] x, y;
      logic [7:0] a0, a1, a2, a3;
      logic [5:0] rc;
      logic [BLOCK_BITS-1:0] result;
      int row, col;
      for (int i = 0; i < 16; i++) begin
         st[i] = plain[8*i +: 8];
         t1[i] = tk1_in[8*i +: 8];
         t2[i] = tk2_in[8*i +: 8];
      end
      rc = '0;
      for (int r = 0; r < ROUNDS; r++) begin
         // round constant steps before use, first value 0x01
         rc = {rc[4:0], rc[5] ^ rc[4] ^ 1'b1};

         // s-box on each cell
         for (int i = 0; i < 16; i++) begin
            x = ~st[i];
            x = x ^ (((x >> 2) & (x >> 3)) & 8'h11);
            y = ((x << 5) & (x << 1)) & 8'h20;
            x = x ^ ((((x << 5) & (x << 4)) & 8'h40) ^ y);
            y = ((x << 2) & (x << 1)) & 8'h80;
            x = x ^ ((((x >> 2) & (x << 1)) & 8'h02) ^ y);
            y = ((x >> 5) & (x << 1)) & 8'h04;
            x = x ^ ((((x >> 1) & (x >> 2)) & 8'h08) ^ y);
            x = ~x;
            st[i] = {x[5], x[4], x[0], x[3], x[1], x[6], x[7], x[2]};
         end

         // round tweakey on the top two rows, constants on cells 0, 4 and 8
         for (int i = 0; i < 8; i++) begin
            st[i] = st[i] ^ t1[i] ^ t2[i];
         end
         st[0] = st[0] ^ {4'h0, rc[3:0]};
         st[4] = st[4] ^ {6'h0, rc[5:4]};
         st[8] = st[8] ^ 8'h02;

         // row r turns right by r cells
         for (int i = 0; i < 16; i++) begin
            row = i / 4;
            col = i % 4;
            sh[i] = st[4*row + ((col - row + 4) % 4)];
         end

         // column mix
         for (int c = 0; c < 4; c++) begin
            a0 = sh[c];
            a1 = sh[4+c];
            a2 = sh[8+c];
            a3 = sh[12+c];
            st[c]    = a0 ^ a2 ^ a3;
            st[4+c]  = a0;
            st[8+c]  = a1 ^ a2;
            st[12+c] = a0 ^ a2;
         end

         // tweakey schedule: permute both, lfsr on the top half of tk2
         for (int i = 0; i < 16; i++) begin
            nt1[i] = t1[tk_perm[i]];
            nt2[i] = t2[tk_perm[i]];
         end
         for (int i = 0; i < 16; i++) begin
            t1[i] = nt1[i];
            t2[i] = (i < 8) ? {nt2[i][6:0], nt2[i][7] ^ nt2[i][5]} : nt2[i];
         end
      end
      for (int i = 0; i < 16; i++) begin
         result[8*i +: 8] = st[i];
      end
      return result;
   endfunction

   // 64-bit value leaning on the extremes now and then
   function automatic logic [HALF_BITS-1:0] pick_word();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2: return 64'd1 << $urandom_range(HALF_BITS - 1);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // offer one plaintext after a random gap, wait for its transfer, log the expected cipher
   task automatic send_block(input logic [BLOCK_BITS-1:0] plain);
      logic [BLOCK_BITS-1:0] cipher;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_block_low  <= plain[HALF_BITS-1:0];
      req_block_high <= plain[BLOCK_BITS-1:HALF_BITS];
      do begin
         @(posedge clock);
      end while (req_stall !== 1'b0);
      cipher = skinny_encrypt(plain,
                              {tweakey_word[CSR_TK1_HIGH], tweakey_word[CSR_TK1_LOW]},
                              {tweakey_word[CSR_TK2_HIGH], tweakey_word[CSR_TK2_LOW]});
      pending_cipher.push_back('{cipher[HALF_BITS-1:0], cipher[BLOCK_BITS-1:HALF_BITS]});
   endtask

   // sender pauses until every outstanding cipher has come back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (pending_cipher.size() != 0) begin
         @(posedge clock);
      end
      repeat (2) @(posedge clock);
   endtask

   // write the tweakey registers that change, or all of them on request
   task automatic load_tweakey(input logic [BLOCK_BITS-1:0] tk1,
                               input logic [BLOCK_BITS-1:0] tk2,
                               input bit rewrite_all);
      logic [HALF_BITS-1:0] word [4];
      csr_index_type idx;
      int i;
      word[CSR_TK1_LOW]  = tk1[HALF_BITS-1:0];
      word[CSR_TK1_HIGH] = tk1[BLOCK_BITS-1:HALF_BITS];
      word[CSR_TK2_LOW]  = tk2[HALF_BITS-1:0];
      word[CSR_TK2_HIGH] = tk2[BLOCK_BITS-1:HALF_BITS];
      for (i = 0; i < 4; i++) begin
         idx = csr_index_type'(i);
         if (rewrite_all || word[idx] != tweakey_word[idx]) begin
            csr_wr_en   <= 1'b1;
            csr_index   <= idx;
            csr_wr_data <= word[idx];
            @(posedge clock);
            tweakey_word[idx] = word[idx];
         end
      end
      csr_wr_en <= 1'b0;
   endtask

   // response side: check each transfer against the oldest expected cipher, then pick the
   // stall for the next cycle (long hold-off first, otherwise random at the phase rate)
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (pending_cipher.size() == 0) begin
            report_mismatch($sformatf("cipher transfer with nothing expected: %h_%h",
                                      rsp_cipher_high, rsp_cipher_low));
         end else begin
            head_cipher = pending_cipher.pop_front();
            if (rsp_cipher_low !== head_cipher.cipher_low) begin
               report_mismatch($sformatf("cipher_low %h, expected %h",
                                         rsp_cipher_low, head_cipher.cipher_low));
            end
            if (rsp_cipher_high !== head_cipher.cipher_high) begin
               report_mismatch($sformatf("cipher_high %h, expected %h",
                                         rsp_cipher_high, head_cipher.cipher_high));
            end
         end
      end
      if (hold_seen != hold_requests) begin
         hold_seen = hold_requests;
         hold_left = HOLD_STALL_CYCLES;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   initial begin
      int settle;
      logic [BLOCK_BITS-1:0] tk1_next, tk2_next;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed rows; the first ones run on the reset tweakey
      foreach (directed_rows[k]) begin
         if (directed_rows[k].tk1 !=
                {tweakey_word[CSR_TK1_HIGH], tweakey_word[CSR_TK1_LOW]} ||
             directed_rows[k].tk2 !=
                {tweakey_word[CSR_TK2_HIGH], tweakey_word[CSR_TK2_LOW]}) begin
            wait_for_drain();
            load_tweakey(directed_rows[k].tk1, directed_rows[k].tk2, 1'b0);
         end
         send_block(directed_rows[k].plain);
      end

      // random part: receiver-heavy idling, then sender-heavy, then none
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 35;
               recv_idle_pct <= 78;
            end
            1: begin
               send_idle_pct = 78;
               recv_idle_pct <= 35;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct <= 0;
            end
         endcase
         for (int chunk = 0; chunk < CHUNKS_PER_PHASE; chunk++) begin
            // new tweakey only once the pipeline is empty
            tk1_next = {pick_word(), pick_word()};
            tk2_next = {pick_word(), pick_word()};
            wait_for_drain();
            load_tweakey(tk1_next, tk2_next, $urandom_range(3) == 0);
            // long receiver hold-off while blocks keep coming, to fill the pipeline
            if (chunk == 1) begin
               hold_requests <= hold_requests + 1;
            end
            for (int n = 0; n < BLOCKS_PER_CHUNK; n++) begin
               send_block({pick_word(), pick_word()});
            end
         end
      end

      // let everything drain, then watch a little longer for strays
      req_valid <= 1'b0;
      settle = 0;
      while (pending_cipher.size() != 0 && settle < DRAIN_LIMIT) begin
         @(posedge clock);
         settle++;
      end
      repeat (DRAIN_MARGIN) @(posedge clock);
      if (pending_cipher.size() != 0) begin
         report_mismatch($sformatf("%0d expected ciphers never arrived",
                                   pending_cipher.size()));
      end

      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

[skinny_128_256_block_encrypt_core.f]
design/skinny_pkg.sv
design/skinny_128_256_block_encrypt_core.sv
design/skinny_checker.sv
bench/tb_skinny_128_256_block_encrypt_core.sv
